[src/qte_pkg.sv]
// Shared constants, arctangent table and angle rounding for the quaternion to Euler converter.
package qte_pkg;

  // Binary angles: 2^32 is one full turn, held in 34 signed bits.
  localparam int AW = 34;
  // Angle times 36000 before rounding.
  localparam int PRW = 51;
  // Square-root datapath width.
  localparam int SQW = 62;

  localparam logic signed [AW-1:0] QUARTER_TURN = 34'sh0_4000_0000;

  localparam logic signed [AW-1:0] ATAN_TAB [32] = '{
    34'sh20000000, 34'sh12E4051E, 34'sh09FB385B, 34'sh051111D4,
    34'sh028B0D43, 34'sh0145D7E1, 34'sh00A2F61E, 34'sh00517C55,
    34'sh0028BE53, 34'sh00145F2F, 34'sh000A2F98, 34'sh000517CC,
    34'sh00028BE6, 34'sh000145F3, 34'sh0000A2FA, 34'sh0000517D,
    34'sh000028BE, 34'sh0000145F, 34'sh00000A30, 34'sh00000518,
    34'sh0000028C, 34'sh00000146, 34'sh000000A3, 34'sh00000051,
    34'sh00000029, 34'sh00000014, 34'sh0000000A, 34'sh00000005,
    34'sh00000003, 34'sh00000001, 34'sh00000001, 34'sh00000000
  };

  // Rounds p / 2^32 to nearest with halves away from zero, then saturates to +-lim.
  function automatic logic signed [15:0] to_hund(input logic signed [PRW-1:0] p,
                                                 input logic [15:0] lim);
    logic [PRW-1:0] mag;
    logic [PRW-1:0] h;
    mag = p[PRW-1] ? PRW'(-p) : PRW'(p);
    h = (mag + (PRW'(1) << 31)) >> 32;
    if (h > PRW'(lim)) h = PRW'(lim);
    return p[PRW-1] ? -$signed(h[15:0]) : $signed(h[15:0]);
  endfunction

endpackage

[src/qte_sqrt_cell.sv]
// One bit step of the restoring integer square root chain.
module qte_sqrt_cell #(
  parameter int SHIFT = 0
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [qte_pkg::SQW-1:0]    n_in,
  input  logic [qte_pkg::SQW-1:0]    r_in,
  output logic [qte_pkg::SQW-1:0]    n_out,
  output logic [qte_pkg::SQW-1:0]    r_out
);
  import qte_pkg::*;

  localparam logic [SQW-1:0] BIT = SQW'(1) << SHIFT;
  logic [SQW-1:0] trial;

  assign trial = r_in + BIT;

  always_ff @(posedge clk) begin
    if (en) begin
      if (n_in >= trial) begin
        n_out <= n_in - trial;
        r_out <= (r_in >> 1) + BIT;
      end else begin
        n_out <= n_in;
        r_out <= r_in >> 1;
      end
    end
  end
endmodule

[src/qte_cordic_cell.sv]
// One vectoring CORDIC rotation with a registered output.
module qte_cordic_cell #(
  parameter int W   = 36,
  parameter int IDX = 0
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [W-1:0]            x_in,
  input  logic signed [W-1:0]            y_in,
  input  logic signed [qte_pkg::AW-1:0]  z_in,
  input  logic                           zero_in,
  output logic signed [W-1:0]            x_out,
  output logic signed [W-1:0]            y_out,
  output logic signed [qte_pkg::AW-1:0]  z_out,
  output logic                           zero_out
);
  import qte_pkg::*;

  logic signed [W-1:0] dx;
  logic signed [W-1:0] dy;

  assign dx = y_in >>> IDX;
  assign dy = x_in >>> IDX;

  always_ff @(posedge clk) begin
    if (en) begin
      zero_out <= zero_in;
      if (!y_in[W-1]) begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + ATAN_TAB[IDX];
      end else begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - ATAN_TAB[IDX];
      end
    end
  end
endmodule

[src/quaternion_to_euler_angles.sv]
// Top level: quaternion to roll, pitch and yaw through pipelined CORDIC and square-root chains.
// Throughput is one word per cycle while the output is not stalled; the pitch path (a 31-cell square-root chain ahead
// of the CORDIC chain) sets the depth, and the roll and yaw results are delayed to match.
// The whole pipeline advances together whenever the output register is empty or taken.
// Synchronous active-high reset clears only the valid bits; data registers are not reset.
module quaternion_to_euler_angles #(
  parameter int FRAC_BITS     = 14,
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic signed [15:0] quat_w,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] roll_angle,
  output logic signed [14:0] pitch_angle,
  output logic signed [15:0] yaw_angle,
  output logic               pitch_clamped
);
  import qte_pkg::*;

  localparam int N     = CORDIC_STAGES;
  // Width of the products' sums: one is 2^(2*FRAC_BITS), the sums reach about 2^33.
  localparam int SW    = ((2 * FRAC_BITS > 32) ? 2 * FRAC_BITS : 32) + 3;
  // CORDIC growth plus the quarter-turn prerotation needs two more bits.
  localparam int CW    = SW + 2;
  localparam int PW    = 34;
  localparam int SQN   = 31;
  localparam int DEPTH = N + 38;
  localparam int SHR   = (2 * FRAC_BITS >= 30) ? 2 * FRAC_BITS - 30 : 0;
  localparam int SHL   = (2 * FRAC_BITS < 30) ? 30 - 2 * FRAC_BITS : 0;
  // The clamp flag is made in the fourth stage and is needed at the output register.
  localparam int CLN   = N + 33;
  // Roll and yaw finish ahead of pitch; this is the depth of their delay line.
  localparam int RYN   = 31;

  // The pipeline moves as one; a stall holds every stage in place.
  logic en;
  logic [DEPTH-1:0] vld;

  assign en        = !vld[DEPTH-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], in_valid};
    end
  end

  // Stage 1: capture the input word.
  logic signed [15:0] qx, qy, qz, qw;
  always_ff @(posedge clk) begin
    if (en) begin
      qx <= quat_x;
      qy <= quat_y;
      qz <= quat_z;
      qw <= quat_w;
    end
  end

  // Stage 2: the nine component products, each its own multiplier.
  logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wz, p_xy, p_zz, p_wy, p_zx;
  always_ff @(posedge clk) begin
    if (en) begin
      p_wx <= qw * qx;
      p_yz <= qy * qz;
      p_xx <= qx * qx;
      p_yy <= qy * qy;
      p_wz <= qw * qz;
      p_xy <= qx * qy;
      p_zz <= qz * qz;
      p_wy <= qw * qy;
      p_zx <= qz * qx;
    end
  end

  // Stage 3: sine and cosine terms at scale 2^(2*FRAC_BITS).
  localparam logic signed [SW-1:0] ONE = SW'(1) <<< (2 * FRAC_BITS);
  logic signed [SW-1:0] sr, cr, sy, cy, sp;
  always_ff @(posedge clk) begin
    if (en) begin
      sr <= (SW'(p_wx) + SW'(p_yz)) <<< 1;
      cr <= ONE - ((SW'(p_xx) + SW'(p_yy)) <<< 1);
      sy <= (SW'(p_wz) + SW'(p_xy)) <<< 1;
      cy <= ONE - ((SW'(p_yy) + SW'(p_zz)) <<< 1);
      sp <= (SW'(p_wy) - SW'(p_zx)) <<< 1;
    end
  end

  // Stage 4: prerotate the arctangent operands into the right half plane, detect a
  // pitch argument at or beyond one, and bring the pitch argument to scale 2^30.
  logic signed [CW-1:0] rx0, ry0, yx0, yy0;
  logic signed [AW-1:0] rz0, yz0;
  logic                 rzero0, yzero0;
  logic signed [31:0]   s30;
  logic [1:0]           clamp_in;

  always_ff @(posedge clk) begin
    if (en) begin
      rzero0 <= (cr == '0) && (sr == '0);
      yzero0 <= (cy == '0) && (sy == '0);
      if (cr[SW-1]) begin
        if (!sr[SW-1]) begin
          rx0 <= CW'(sr);
          ry0 <= -CW'(cr);
          rz0 <= QUARTER_TURN;
        end else begin
          rx0 <= -CW'(sr);
          ry0 <= CW'(cr);
          rz0 <= -QUARTER_TURN;
        end
      end else begin
        rx0 <= CW'(cr);
        ry0 <= CW'(sr);
        rz0 <= '0;
      end
      if (cy[SW-1]) begin
        if (!sy[SW-1]) begin
          yx0 <= CW'(sy);
          yy0 <= -CW'(cy);
          yz0 <= QUARTER_TURN;
        end else begin
          yx0 <= -CW'(sy);
          yy0 <= CW'(cy);
          yz0 <= -QUARTER_TURN;
        end
      end else begin
        yx0 <= CW'(cy);
        yy0 <= CW'(sy);
        yz0 <= '0;
      end
      s30      <= 32'((sp >>> SHR) <<< SHL);
      clamp_in <= {(sp >= ONE) || (sp <= -ONE), sp > 0};
    end
  end

  // Stage 5: squared cosine (1 - s)(1 + s) at scale 2^60. A clamped word carries
  // meaningless data down the pitch chain; its angle is replaced at the end.
  logic [SQW-1:0]     c2;
  logic signed [32:0] c_lo, c_hi;
  logic signed [65:0] c_prod;
  assign c_lo   = (33'sd1 <<< 30) - 33'(s30);
  assign c_hi   = (33'sd1 <<< 30) + 33'(s30);
  assign c_prod = c_lo * c_hi;

  always_ff @(posedge clk) begin
    if (en) begin
      c2 <= c_prod[SQW-1:0];
    end
  end

  // Square-root chain: one result bit per cell, from bit 30 down to bit 0.
  logic [SQW-1:0] sq_n [SQN+1];
  logic [SQW-1:0] sq_r [SQN+1];
  assign sq_n[0] = c2;
  assign sq_r[0] = '0;

  for (genvar k = 0; k < SQN; k++) begin : g_sqrt
    qte_sqrt_cell #(.SHIFT(60 - 2 * k)) u_cell (
      .clk   (clk),
      .en    (en),
      .n_in  (sq_n[k]),
      .r_in  (sq_r[k]),
      .n_out (sq_n[k+1]),
      .r_out (sq_r[k+1])
    );
  end

  // The pitch sine rides alongside the square-root chain.
  logic signed [31:0] s30_dly [SQN+1];
  always_ff @(posedge clk) begin
    if (en) begin
      s30_dly[0] <= s30;
      for (int k = 1; k < SQN + 1; k++) s30_dly[k] <= s30_dly[k-1];
    end
  end

  // Three CORDIC chains of the same cell; the pitch chain uses a narrower width.
  logic signed [CW-1:0] rx [N+1];
  logic signed [CW-1:0] ry [N+1];
  logic signed [AW-1:0] rz [N+1];
  logic                 rzf [N+1];
  logic signed [CW-1:0] yx [N+1];
  logic signed [CW-1:0] yy [N+1];
  logic signed [AW-1:0] yz [N+1];
  logic                 yzf [N+1];
  logic signed [PW-1:0] px [N+1];
  logic signed [PW-1:0] py [N+1];
  logic signed [AW-1:0] pz [N+1];
  logic                 pzf [N+1];

  assign rx[0]  = rx0;
  assign ry[0]  = ry0;
  assign rz[0]  = rz0;
  assign rzf[0] = rzero0;
  assign yx[0]  = yx0;
  assign yy[0]  = yy0;
  assign yz[0]  = yz0;
  assign yzf[0] = yzero0;
  assign px[0]  = $signed(PW'(sq_r[SQN][30:0]));
  assign py[0]  = PW'(s30_dly[SQN]);
  assign pz[0]  = '0;
  assign pzf[0] = 1'b0;

  for (genvar i = 0; i < N; i++) begin : g_cordic
    qte_cordic_cell #(.W(CW), .IDX(i)) u_roll (
      .clk (clk), .en (en),
      .x_in (rx[i]), .y_in (ry[i]), .z_in (rz[i]), .zero_in (rzf[i]),
      .x_out (rx[i+1]), .y_out (ry[i+1]), .z_out (rz[i+1]), .zero_out (rzf[i+1])
    );
    qte_cordic_cell #(.W(CW), .IDX(i)) u_yaw (
      .clk (clk), .en (en),
      .x_in (yx[i]), .y_in (yy[i]), .z_in (yz[i]), .zero_in (yzf[i]),
      .x_out (yx[i+1]), .y_out (yy[i+1]), .z_out (yz[i+1]), .zero_out (yzf[i+1])
    );
    qte_cordic_cell #(.W(PW), .IDX(i)) u_pitch (
      .clk (clk), .en (en),
      .x_in (px[i]), .y_in (py[i]), .z_in (pz[i]), .zero_in (pzf[i]),
      .x_out (px[i+1]), .y_out (py[i+1]), .z_out (pz[i+1]), .zero_out (pzf[i+1])
    );
  end

  // Binary angle to hundredths of a degree: multiply, then round and saturate.
  localparam logic signed [16:0] DEG100 = 17'sd36000;
  logic signed [AW-1:0]  r_ang, y_ang;
  logic signed [PRW-1:0] r_prod, y_prod, p_prod;
  logic signed [15:0]    r_hund, y_hund;

  assign r_ang = rzf[N] ? '0 : rz[N];
  assign y_ang = yzf[N] ? '0 : yz[N];

  always_ff @(posedge clk) begin
    if (en) begin
      r_prod <= r_ang * DEG100;
      y_prod <= y_ang * DEG100;
      p_prod <= $signed(pzf[N] ? '0 : pz[N]) * DEG100;
      r_hund <= to_hund(r_prod, 16'd18000);
      y_hund <= to_hund(y_prod, 16'd18000);
    end
  end

  // Roll and yaw wait for the pitch; the clamp flag and its sign wait too.
  logic [31:0] ry_dly [RYN];
  logic [1:0]  cl_dly [CLN];
  always_ff @(posedge clk) begin
    if (en) begin
      ry_dly[0] <= {r_hund, y_hund};
      for (int k = 1; k < RYN; k++) ry_dly[k] <= ry_dly[k-1];
      cl_dly[0] <= clamp_in;
      for (int k = 1; k < CLN; k++) cl_dly[k] <= cl_dly[k-1];
    end
  end

  // Output register.
  logic signed [15:0] p_hund;
  assign p_hund = to_hund(p_prod, 16'd9000);

  always_ff @(posedge clk) begin
    if (en) begin
      roll_angle    <= $signed(ry_dly[RYN-1][31:16]);
      yaw_angle     <= $signed(ry_dly[RYN-1][15:0]);
      pitch_clamped <= cl_dly[CLN-1][1];
      if (cl_dly[CLN-1][1]) begin
        pitch_angle <= cl_dly[CLN-1][0] ? 15'sd9000 : -15'sd9000;
      end else begin
        pitch_angle <= p_hund[14:0];
      end
    end
  end
endmodule

[src/qte_checker.sv]
// Port-level checks for the quaternion to Euler converter, bound to the top level.
module qte_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] roll_angle,
  input logic signed [14:0] pitch_angle,
  input logic signed [15:0] yaw_angle,
  input logic               pitch_clamped
);

  // A held result word keeps its roll and pitch values.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(roll_angle) && $stable(pitch_angle))
    else $error("result word changed while stalled");

  // Input is taken exactly when the output register is free or being drained.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output backpressure");

  // A clamped pitch is exactly a right angle.
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid && pitch_clamped |-> pitch_angle == 15'sd9000 || pitch_angle == -15'sd9000)
    else $error("clamped pitch is not a right angle");

  // Roll and yaw angles stay in range.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> roll_angle <= 16'sd18000 && roll_angle >= -16'sd18000 &&
                  yaw_angle <= 16'sd18000 && yaw_angle >= -16'sd18000)
    else $error("roll or yaw out of range");

endmodule

bind quaternion_to_euler_angles qte_checker u_qte_checker (.*);
